// File: rtl/trie_pkg.sv
// ----------------------------------------------------------------------------
// trie_pkg : shared types and constants of the letter trie block
// Command and status structures between controller and datapath, result codes
// and character constants.
// ----------------------------------------------------------------------------
package trie_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int NODE_COUNT_DEF = 256;
  localparam int WORD_MAX_DEF   = 32;

  // Fan-out of one trie node and the character range it covers.
  localparam int         LETTERS = 26;
  localparam logic [7:0] ASCII_A = 8'h41;
  localparam logic [7:0] ASCII_Z = 8'(ASCII_A + LETTERS - 1);
  // Clearing this bit folds lower case onto upper case.
  localparam logic [7:0] CASE_MASK = 8'hDF;

  // Operation selector.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_POOL_FULL = 3'd4;

  // How the node and end mark fields of a result are formed.
  localparam logic [1:0] RK_NONE = 2'd0;  // node 0, end mark 0
  localparam logic [1:0] RK_END1 = 2'd1;  // current node, end mark 1
  localparam logic [1:0] RK_MARK = 2'd2;  // current node, end mark as read

  typedef struct packed {
    logic       take;
    logic       start;
    logic       link_rd;
    logic       step;
    logic       alloc;
    logic       mark_wr;
    logic       mark_rd;
    logic       res_set;
    logic [2:0] res_status;
    logic [1:0] res_kind;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic word_ends;
    logic bad;
    logic ovf;
    logic len_zero;
    logic is_insert;
    logic last_step;
    logic child_zero;
    logic pool_full;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/trie_word_insert_and_prefix_find_top.sv
// ----------------------------------------------------------------------------
// trie_word_insert_and_prefix_find_top : letter trie with insert and find
// Case-insensitive 26-way trie kept in a node pool. Words arrive one character
// per item, are buffered, and are then inserted into or searched in the trie.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata                      tuser              tlast
// s_axis    in   letter[7:0]                func, char_present last
// m_axis    out  node_index[7:0], is_end[8] status[2:0]        -
//
// Character items are taken back to back while the block is idle. The item
// that ends a word starts a walk: a check step, then for each buffered letter
// one read of the child link memory and one update of the current node, then
// the end mark and output steps; words rejected early go straight to output.
// After reset a clearing pass zeroes the child link memory one entry a cycle,
// NODE_COUNT * 26 entries in all, and no item is taken until it ends. A result
// waits in an output register, so a stalled master side only holds the block
// when the next word's walk has finished.
//
module trie_word_insert_and_prefix_find_top #(
  parameter int NODE_COUNT = trie_pkg::NODE_COUNT_DEF,
  parameter int WORD_MAX   = trie_pkg::WORD_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input characters.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] letter
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] char_present
  input  logic        s_axis_tlast,
  // Results, one for each ended word.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] node_index, [8] node_is_end, rest zero
  output logic [2:0]  m_axis_tuser    // [2:0] status
);
  import trie_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] res_status;
  logic [7:0] res_node;
  logic       res_end;

  // The sequencer owns the input handshake; the datapath owns the output one.
  trie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trie_dp #(
    .NODE_COUNT (NODE_COUNT),
    .WORD_MAX   (WORD_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_func_i    (s_axis_tuser[0]),
    .in_present_i (s_axis_tuser[1]),
    .in_letter_i  (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (res_status),
    .out_node_o   (res_node),
    .out_end_o    (res_end)
  );

  // Pack the result fields, highest field first.
  assign m_axis_tdata = {7'b0, res_end, res_node};
  assign m_axis_tuser = res_status;

endmodule

// File: rtl/trie_ctrl.sv
// ----------------------------------------------------------------------------
// trie_ctrl : sequencer of the letter trie block
// Steps through the clearing pass, character buffering and the trie walk, and
// drives the datapath by command signals.
// ----------------------------------------------------------------------------
module trie_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  trie_pkg::sts_t sts_i,
  output trie_pkg::cmd_t cmd_o
);
  import trie_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_LINK   = 3'd3;
  localparam logic [2:0] S_STEP   = 3'd4;
  localparam logic [2:0] S_END    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.word_ends) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.start = 1'b1;
        if (sts_i.bad) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = sts_i.is_insert ? ST_REJECTED : ST_NOT_FOUND;
          cmd_o.res_kind   = RK_NONE;
          state_d          = S_FINISH;
        end else if (sts_i.ovf) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_TOO_LONG;
          cmd_o.res_kind   = RK_NONE;
          state_d          = S_FINISH;
        end else if (sts_i.len_zero) begin
          if (sts_i.is_insert) begin
            state_d = S_END;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_NOT_FOUND;
            cmd_o.res_kind   = RK_NONE;
            state_d          = S_FINISH;
          end
        end else begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.link_rd = 1'b1;
        state_d       = S_STEP;
      end
      S_STEP: begin
        if (sts_i.child_zero && !sts_i.is_insert) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          cmd_o.res_kind   = RK_NONE;
          state_d          = S_FINISH;
        end else if (sts_i.child_zero && sts_i.pool_full) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_POOL_FULL;
          cmd_o.res_kind   = RK_NONE;
          state_d          = S_FINISH;
        end else begin
          cmd_o.alloc = sts_i.child_zero;
          cmd_o.step  = !sts_i.child_zero;
          state_d     = sts_i.last_step ? S_END : S_LINK;
        end
      end
      S_END: begin
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ST_DONE;
        if (sts_i.is_insert) begin
          cmd_o.mark_wr  = 1'b1;
          cmd_o.res_kind = RK_END1;
        end else begin
          cmd_o.mark_rd  = 1'b1;
          cmd_o.res_kind = RK_MARK;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/trie_dp.sv
// ----------------------------------------------------------------------------
// trie_dp : datapath of the letter trie block
// Word buffer, child link and end mark memories, node allocation counter,
// walk registers and the output register.
// ----------------------------------------------------------------------------
module trie_dp #(
  parameter int NODE_COUNT = trie_pkg::NODE_COUNT_DEF,
  parameter int WORD_MAX   = trie_pkg::WORD_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  trie_pkg::cmd_t cmd_i,
  output trie_pkg::sts_t sts_o,
  input  logic           in_func_i,
  input  logic           in_present_i,
  input  logic [7:0]     in_letter_i,
  input  logic           in_last_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [2:0]     out_status_o,
  output logic [7:0]     out_node_o,
  output logic           out_end_o
);
  import trie_pkg::*;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int NF_W       = $clog2(NODE_COUNT + 1);
  localparam int LINK_DEPTH = NODE_COUNT * LETTERS;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int LEN_W      = $clog2(WORD_MAX + 1);
  localparam int IDX_W      = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

  localparam logic [LINK_AW-1:0] LETTERS_A   = LINK_AW'(LETTERS);
  localparam logic [LINK_AW-1:0] CLR_LAST    = LINK_AW'(LINK_DEPTH - 1);
  localparam logic [LINK_AW-1:0] CLR_MARKS   = LINK_AW'(NODE_COUNT);
  localparam logic [NF_W-1:0]    NF_LIMIT    = NF_W'(NODE_COUNT);
  localparam logic [LEN_W-1:0]   LEN_LIMIT   = LEN_W'(WORD_MAX);

  // Memories.
  logic [4:0]        buf_mem  [WORD_MAX];
  logic [NODE_W-1:0] link_mem [LINK_DEPTH];
  logic              mark_mem [NODE_COUNT];

  // Clearing pass.
  logic [LINK_AW-1:0] clr_q, clr_d;
  logic               clear_done_q, clear_done_d;

  // Word state.
  logic [LEN_W-1:0] len_q, len_d;
  logic             bad_q, bad_d;
  logic             ovf_q, ovf_d;
  logic             func_q;

  // Walk state.
  logic [NODE_W-1:0]  cur_q, cur_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [NF_W-1:0]    nf_q, nf_d;
  logic [LINK_AW-1:0] link_addr_q, link_addr_d;
  logic [4:0]         buf_rdata_q;
  logic [NODE_W-1:0]  link_rdata_q;
  logic               mark_rdata_q;
  logic [2:0]         res_status_q;
  logic [1:0]         res_kind_q;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [2:0] out_status_q;
  logic [7:0] out_node_q;
  logic       out_end_q;

  // Character decode.
  logic [7:0] up_char;
  logic       is_letter;
  logic [4:0] letter_idx;
  logic       buf_we;
  logic       buf_re;
  logic [IDX_W-1:0] buf_raddr;
  logic [LEN_W-1:0] nxt_idx;
  logic             last_step;
  logic             clr_active;
  logic             link_we;
  logic [LINK_AW-1:0] link_waddr;
  logic [NODE_W-1:0]  link_wdata;
  logic               mark_we;
  logic [NODE_W-1:0]  mark_waddr;
  logic [NODE_W+7:0]  cur_wide;

  assign up_char    = in_letter_i & CASE_MASK;
  assign is_letter  = (up_char >= ASCII_A) && (up_char <= ASCII_Z);
  assign letter_idx = 5'(up_char - ASCII_A);

  assign nxt_idx    = idx_q + 1'b1;
  assign last_step  = (nxt_idx == len_q);
  assign clr_active = !clear_done_q;

  assign buf_we    = cmd_i.take && in_present_i && is_letter && (len_q < LEN_LIMIT);
  assign buf_re    = cmd_i.start || (cmd_i.link_rd && !last_step);
  assign buf_raddr = cmd_i.start ? '0 : nxt_idx[IDX_W-1:0];

  assign link_addr_d = LINK_AW'(cur_q) * LETTERS_A + LINK_AW'(buf_rdata_q);

  assign link_we    = clr_active || cmd_i.alloc;
  assign link_waddr = clr_active ? clr_q : link_addr_q;
  assign link_wdata = clr_active ? '0 : nf_q[NODE_W-1:0];

  assign mark_we    = (clr_active && (clr_q < CLR_MARKS)) || cmd_i.mark_wr;
  assign mark_waddr = clr_active ? clr_q[NODE_W-1:0] : cur_q;

  assign cur_wide = {8'b0, cur_q};

  // Control registers.
  always_comb begin
    clr_d        = clr_q;
    clear_done_d = clear_done_q;
    if (clr_active) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == CLR_LAST) begin
        clear_done_d = 1'b1;
      end
    end

    len_d = len_q;
    bad_d = bad_q;
    ovf_d = ovf_q;
    if (cmd_i.take && in_present_i) begin
      if (!is_letter) begin
        bad_d = 1'b1;
      end else if (len_q >= LEN_LIMIT) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      len_d = '0;
      bad_d = 1'b0;
      ovf_d = 1'b0;
    end

    cur_d = cur_q;
    idx_d = idx_q;
    nf_d  = nf_q;
    if (cmd_i.start) begin
      cur_d = '0;
      idx_d = '0;
    end else if (cmd_i.step) begin
      cur_d = link_rdata_q;
      idx_d = nxt_idx;
    end else if (cmd_i.alloc) begin
      cur_d = nf_q[NODE_W-1:0];
      idx_d = nxt_idx;
      nf_d  = nf_q + 1'b1;
    end

    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      clear_done_q <= 1'b0;
      len_q        <= '0;
      bad_q        <= 1'b0;
      ovf_q        <= 1'b0;
      nf_q         <= NF_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      clr_q        <= clr_d;
      clear_done_q <= clear_done_d;
      len_q        <= len_d;
      bad_q        <= bad_d;
      ovf_q        <= ovf_d;
      nf_q         <= nf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    if (cmd_i.take) begin
      func_q <= in_func_i;
    end
    if (cmd_i.link_rd) begin
      link_addr_q <= link_addr_d;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_kind_q   <= cmd_i.res_kind;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      case (res_kind_q)
        RK_END1: begin
          out_node_q <= cur_wide[7:0];
          out_end_q  <= 1'b1;
        end
        RK_MARK: begin
          out_node_q <= cur_wide[7:0];
          out_end_q  <= mark_rdata_q;
        end
        default: begin
          out_node_q <= '0;
          out_end_q  <= 1'b0;
        end
      endcase
    end
  end

  // Word buffer.
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[len_q[IDX_W-1:0]] <= letter_idx;
    end
    if (buf_re) begin
      buf_rdata_q <= buf_mem[buf_raddr];
    end
  end

  // Child links.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd_i.link_rd) begin
      link_rdata_q <= link_mem[link_addr_d];
    end
  end

  // End marks.
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= !clr_active;
    end
    if (cmd_i.mark_rd) begin
      mark_rdata_q <= mark_mem[cur_q];
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clear_done = clear_done_q;
    sts_o.word_ends  = !in_present_i || in_last_i;
    sts_o.bad        = bad_q;
    sts_o.ovf        = ovf_q;
    sts_o.len_zero   = (len_q == '0);
    sts_o.is_insert  = (func_q == FUNC_INSERT);
    sts_o.last_step  = last_step;
    sts_o.child_zero = (link_rdata_q == '0);
    sts_o.pool_full  = (nf_q >= NF_LIMIT);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_node_o   = out_node_q;
  assign out_end_o    = out_end_q;

`ifndef SYNTHESIS
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= NF_LIMIT)
    else $error("node allocation counter ran past the pool");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_LIMIT)
    else $error("word length ran past the buffer");

  a_alloc_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |-> (link_rdata_q == '0) && (nf_q < NF_LIMIT))
    else $error("node allocated over an existing link or from a full pool");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> clear_done_q)
    else $error("character taken during the clearing pass");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while its item waits");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking testbench of the letter trie insert and find block
// Words are sent one character per item on the slave side; a behavioural
// trie in the testbench predicts the result of every ended word, and each
// result on the master side is compared field by field with the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import trie_pkg::*;

  localparam int NODES      = NODE_COUNT_DEF;
  localparam int WORD_CAP   = WORD_MAX_DEF;
  localparam int ITEM_GOAL  = 600;
  // Rough number of items that the pool test sends after the random words.
  localparam int POOL_SHARE = 250;

  typedef struct {
    logic [2:0] status;
    logic [7:0] node;
    logic       is_end;
  } trie_result_t;

  // DUT connections; every input has a known value from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // Behavioural copy of the trie and of the word being collected.
  int unsigned  link_mem [NODES * LETTERS];
  bit           mark_mem [NODES];
  int unsigned  free_node;
  logic [4:0]   word_q [WORD_CAP];
  int unsigned  word_len;
  bit           saw_bad;
  bit           saw_ovf;

  trie_result_t expected_results [$];
  logic [2:0]   last_status;
  string        inserted_words [$];
  int unsigned  items_sent;
  int unsigned  mismatch_count;
  bit           no_idle;

  trie_word_insert_and_prefix_find_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Safety net: the slowest legal run finishes far inside this time.
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit is_alpha(logic [7:0] ch);
    return (ch >= ASCII_A && ch <= ASCII_Z) || (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

  // Insert of the buffered word: walk from the root, taking fresh nodes
  // from the free counter where a link is missing.
  function automatic trie_result_t word_insert();
    trie_result_t r;
    int unsigned  cur;
    int unsigned  slot;
    r = '{ST_DONE, 8'd0, 1'b0};
    cur = 0;
    if (saw_bad) begin
      r.status = ST_REJECTED;
      return r;
    end
    if (saw_ovf) begin
      r.status = ST_TOO_LONG;
      return r;
    end
    for (int unsigned i = 0; i < word_len; i++) begin
      slot = cur * LETTERS + word_q[i];
      if (link_mem[slot] == 0) begin
        // Nodes already linked on the way stay in the trie, unmarked.
        if (free_node >= NODES) begin
          r.status = ST_POOL_FULL;
          return r;
        end
        link_mem[slot] = free_node;
        free_node++;
      end
      cur = link_mem[slot];
    end
    mark_mem[cur] = 1'b1;
    r.node   = cur[7:0];
    r.is_end = 1'b1;
    return r;
  endfunction

  // Find of the buffered prefix: a non-letter or an empty prefix is simply
  // not found.
  function automatic trie_result_t prefix_find();
    trie_result_t r;
    int unsigned  cur;
    int unsigned  nxt;
    r = '{ST_NOT_FOUND, 8'd0, 1'b0};
    cur = 0;
    if (saw_bad) return r;
    if (saw_ovf) begin
      r.status = ST_TOO_LONG;
      return r;
    end
    if (word_len == 0) return r;
    for (int unsigned i = 0; i < word_len; i++) begin
      nxt = link_mem[cur * LETTERS + word_q[i]];
      if (nxt == 0 || nxt >= NODES) return r;
      cur = nxt;
    end
    r.status = ST_DONE;
    r.node   = cur[7:0];
    r.is_end = mark_mem[cur];
    return r;
  endfunction

  // Takes one accepted item; returns 1 when it ends a word, with the result.
  function automatic bit trie_apply_char(logic func, logic present, logic [7:0] ch,
                                         logic last, output trie_result_t res);
    logic [7:0] up;
    res = '{ST_DONE, 8'd0, 1'b0};
    if (present) begin
      up = ch & CASE_MASK;
      if (!is_alpha(ch)) begin
        saw_bad = 1'b1;
      end else if (word_len >= WORD_CAP) begin
        saw_ovf = 1'b1;
      end else begin
        word_q[word_len] = 5'(up - ASCII_A);
        word_len++;
      end
      if (!last) return 1'b0;
    end
    res = (func == FUNC_INSERT) ? word_insert() : prefix_find();
    word_len = 0;
    saw_bad  = 1'b0;
    saw_ovf  = 1'b0;
    return 1'b1;
  endfunction

  // Sends one item, with an occasional gap before it. Valid is left high on
  // return; whoever waits next lowers it at the following falling edge.
  task automatic send_item(logic func, logic present, logic [7:0] ch, logic last);
    int unsigned  gap;
    trie_result_t res;
    if (!no_idle && $urandom_range(0, 99) < 17) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    s_axis_tuser  = {present, func};
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (trie_apply_char(func, present, ch, last, res)) begin
      expected_results.push_back(res);
      last_status = res.status;
    end
  endtask

  // Sends a word with random case. The operation only matters on the item
  // that ends the word, so the others carry a random one. A word may also be
  // closed by an item without a character; an empty string is always so.
  task automatic send_word(logic func, string w, bit end_blank);
    logic [7:0] c;
    bit         ends_here;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (is_alpha(c) && $urandom_range(0, 1)) c = c ^ 8'h20;
      ends_here = (i == w.len() - 1) && !end_blank;
      send_item(ends_here ? func : 1'($urandom_range(0, 1)), 1'b1, c, ends_here);
    end
    if (w.len() == 0 || end_blank)
      send_item(func, 1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic string make_word(int unsigned len, bit narrow);
    string      s;
    logic [7:0] c;
    s = "";
    for (int unsigned i = 0; i < len; i++) begin
      c = ASCII_A + 8'(narrow ? $urandom_range(0, 3) : $urandom_range(0, LETTERS - 1));
      if ($urandom_range(0, 1)) c = c | 8'h20;
      s = {s, " "};
      s[s.len() - 1] = c;
    end
    return s;
  endfunction

  // A string cannot hold a zero byte, so that one is never picked here.
  function automatic logic [7:0] pick_non_letter();
    logic [7:0] c;
    do c = 8'($urandom); while (is_alpha(c) || c == 8'h00);
    return c;
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 5);
    if (r < 95) return $urandom_range(6, 12);
    return $urandom_range(13, WORD_CAP);
  endfunction

  // Receiver: stalls at random with a chance of 17 in a hundred, except in quiet stretches.
  always @(negedge clk_i) begin
    m_axis_tready = no_idle || ($urandom_range(0, 99) >= 17);
  end

  // Result checker, sampling at the rising edge.
  always @(posedge clk_i) begin
    trie_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation: status %0d node %0d end %0d",
               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8]);
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tuser !== e.status) begin
          $error("status mismatch: expected %0d, actual %0d", e.status, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[7:0] !== e.node) begin
          $error("node_index mismatch: expected %0d, actual %0d",
                 e.node, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[8] !== e.is_end) begin
          $error("node_is_end mismatch: expected %0d, actual %0d",
                 e.is_end, m_axis_tdata[8]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:9] !== 7'd0) begin
          $error("tdata padding mismatch: expected 0, actual %0h", m_axis_tdata[15:9]);
          mismatch_count++;
        end
      end
    end
  end

  // Empty words, a short insert and its prefixes, and each non-letter
  // class at the edges of the letter ranges.
  task automatic test_directed();
    string w;
    send_word(FUNC_FIND, "", 1'b0);     // empty prefix is never found
    send_word(FUNC_INSERT, "", 1'b0);   // empty insert marks the root
    send_word(FUNC_FIND, "", 1'b0);
    send_word(FUNC_INSERT, "Ab", 1'b0);
    send_word(FUNC_FIND, "aB", 1'b0);
    send_word(FUNC_FIND, "a", 1'b0);    // prefix node, not a word end
    send_word(FUNC_FIND, "c", 1'b0);    // missing child
    send_word(FUNC_INSERT, "b", 1'b1);  // closed by an item without a character
    w = "A@";
    send_word(FUNC_INSERT, w, 1'b0);
    w = "Z[";
    send_word(FUNC_INSERT, w, 1'b0);
    w = "{";
    send_word(FUNC_FIND, w, 1'b0);
    w = "`a";
    send_word(FUNC_FIND, w, 1'b0);
    // The zero byte cannot sit in a string, so this word goes item by item.
    send_item(FUNC_INSERT, 1'b1, 8'h00, 1'b0);
    send_item(FUNC_INSERT, 1'b1, 8'hFF, 1'b1);
    send_word(FUNC_FIND, "AB", 1'b0);   // the rejected words left no trace
    wait_drained();
  endtask

  // Words at and beyond the buffer size, and a non-letter in an overlong word,
  // which must be reported as a non-letter.
  task automatic test_word_length();
    string w;
    w = make_word(WORD_CAP, 1'b0);
    send_word(FUNC_INSERT, w, 1'b0);
    send_word(FUNC_FIND, w, 1'b0);
    inserted_words.push_back(w);
    w = make_word(WORD_CAP + 1, 1'b0);
    send_word(FUNC_INSERT, w, 1'b0);
    send_word(FUNC_FIND, w, 1'b0);
    send_word(FUNC_FIND, w.substr(0, WORD_CAP - 1), 1'b0);
    w = make_word(WORD_CAP + 2, 1'b1);
    w[WORD_CAP + 1] = pick_non_letter();
    send_word(FUNC_INSERT, w, 1'b0);
    w = make_word(WORD_CAP + 8, 1'b1);
    w[3] = pick_non_letter();
    send_word(FUNC_FIND, w, 1'b1);
    wait_drained();
  endtask

  // Mostly inserts over a narrow alphabet, so that later words share
  // prefixes, and finds of prefixes of words already stored; the rest is
  // empty words, non-letters, overlong words and noise.
  task automatic test_random_words();
    string       w;
    int unsigned r;
    int unsigned words;
    logic        func;
    bit          blank;
    words = 0;
    while (items_sent < ITEM_GOAL - POOL_SHARE) begin
      no_idle = (words >= 2 && words < 16);
      r       = $urandom_range(0, 99);
      func    = 1'($urandom_range(0, 1));
      blank   = ($urandom_range(0, 9) == 0);
      if (r < 40) begin
        w = make_word(pick_length(), 1'b1);
        send_word(FUNC_INSERT, w, blank);
        inserted_words.push_back(w);
      end else if (r < 70 && inserted_words.size() != 0) begin
        w = inserted_words[$urandom_range(0, inserted_words.size() - 1)];
        send_word(FUNC_FIND, w.substr(0, $urandom_range(1, w.len()) - 1), blank);
      end else if (r < 78) begin
        send_word(FUNC_FIND, make_word(pick_length(), 1'b1), blank);
      end else if (r < 84) begin
        w = make_word(pick_length(), 1'b1);
        w[$urandom_range(0, w.len() - 1)] = pick_non_letter();
        send_word(func, w, blank);
      end else if (r < 89) begin
        send_word(func, "", 1'b0);
      end else if (r < 92) begin
        send_word(func, make_word($urandom_range(WORD_CAP + 1, WORD_CAP + 4), 1'b1),
                  blank);
      end else if (r < 96) begin
        send_word(FUNC_INSERT, make_word($urandom_range(1, 6), 1'b0), blank);
      end else begin
        // Raw bytes, letters and non-letters alike.
        w = make_word($urandom_range(1, 4), 1'b0);
        for (int i = 0; i < w.len(); i++) w[i] = 8'($urandom);
        send_word(func, w, blank);
      end
      words++;
      if (words % 50 == 0) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Long words over the whole alphabet until the pool runs dry, then finds
  // along the path of the failed insert, whose linked nodes stay unmarked.
  task automatic test_pool_full();
    string w;
    int    tries;
    tries = 0;
    last_status = ST_DONE;
    while (last_status != ST_POOL_FULL && tries < 80) begin
      w = make_word(12, 1'b0);
      send_word(FUNC_INSERT, w, 1'b0);
      tries++;
    end
    for (int n = 1; n <= w.len(); n += 3)
      send_word(FUNC_FIND, w.substr(0, n - 1), 1'b0);
    send_word(FUNC_INSERT, make_word(3, 1'b0), 1'b0);
    if (inserted_words.size() != 0) begin
      // Words already stored need no new node.
      send_word(FUNC_INSERT, inserted_words[0], 1'b0);
      send_word(FUNC_FIND, inserted_words[0], 1'b0);
    end
    send_word(FUNC_INSERT, "", 1'b0);
    wait_drained();
  endtask

  initial begin
    foreach (link_mem[i]) link_mem[i] = 0;
    foreach (mark_mem[i]) mark_mem[i] = 1'b0;
    free_node      = 1;
    word_len       = 0;
    saw_bad        = 1'b0;
    saw_ovf        = 1'b0;
    items_sent     = 0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    last_status    = ST_DONE;

    // The block clears its link memory after reset and holds tready low
    // meanwhile, so the first item simply waits on the handshake.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_word_length();
    test_random_words();
    test_pool_full();

    // Let any stray result show up.
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: trie_word_insert_and_prefix_find_top.f
rtl/trie_pkg.sv
rtl/trie_ctrl.sv
rtl/trie_dp.sv
rtl/trie_word_insert_and_prefix_find_top.sv
test/tb.sv
